[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the integer literal parser.
// Assertions compile only when SYNTHESIS is not defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising edge, suppressed while reset is high.
`define ILP_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("integer literal parser assertion failed");
// Checked at every rising edge, reset included.
`define ILP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("integer literal parser assertion failed");
`else
`define ILP_ASSERT(label, clk, rst, prop)
`define ILP_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

[rtl/ilp_pkg.sv]
// Types, character codes and the digit decoder of the integer literal parser.
// Depends on nothing.
`default_nettype none
package ilp_pkg;

  localparam int SYMBOL_WIDTH = 8;
  localparam int NUMBER_WIDTH = 64;
  localparam int DIGIT_WIDTH  = 5;

  typedef logic [SYMBOL_WIDTH-1:0] symbol_t;
  typedef logic [DIGIT_WIDTH-1:0]  digit_t;

  localparam symbol_t CHAR_UNDERSCORE = 8'h5F;
  localparam symbol_t CHAR_LOWER_X    = 8'h78;
  localparam symbol_t CHAR_LOWER_B    = 8'h62;
  localparam symbol_t CHAR_UPPER_B    = 8'h42;
  localparam symbol_t CHAR_ZERO       = 8'h30;
  localparam symbol_t CHAR_ONE        = 8'h31;
  localparam symbol_t CHAR_NINE       = 8'h39;
  localparam symbol_t CHAR_LOWER_A    = 8'h61;
  localparam symbol_t CHAR_LOWER_F    = 8'h66;
  localparam symbol_t CHAR_UPPER_A    = 8'h41;
  localparam symbol_t CHAR_UPPER_F    = 8'h46;

  // Code returned for a character that is no digit in any base.
  localparam digit_t DIGIT_NONE = 5'h1F;

  // Position of the next character within the token.
  typedef enum logic [2:0] {
    POS_FIRST  = 3'b001,
    POS_SECOND = 3'b010,
    POS_LATER  = 3'b100
  } char_pos_t;

  // Radix of the token. MODE_ZERO is decimal after a leading zero that may
  // still become the hex prefix.
  typedef enum logic [1:0] {
    MODE_DEC  = 2'd0,
    MODE_HEX  = 2'd1,
    MODE_BIN  = 2'd2,
    MODE_ZERO = 2'd3
  } radix_mode_t;

  function automatic digit_t digit_of(input symbol_t c);
    digit_t d;
    d = DIGIT_NONE;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = DIGIT_WIDTH'(c - CHAR_ZERO);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      d = DIGIT_WIDTH'(c - CHAR_LOWER_A) + 5'd10;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      d = DIGIT_WIDTH'(c - CHAR_UPPER_A) + 5'd10;
    end
    return d;
  endfunction

endpackage
`default_nettype wire

[rtl/integer_literal_parser.sv]
// Top level of the integer literal parser: input register, per-character
// parse logic and result register. Uses ilp_pkg and assert_macros.svh.
//
// The block reads an integer literal one character per item, with
// end_of_token high on the last character, and delivers one result per token:
// is_valid and the value, sign-extended to 64 bits from VALUE_WIDTH bits. A
// leading "0x" selects hex, a leading 'b' or 'B' followed by '0' or '1'
// selects binary, and anything else is read as decimal. Underscores are
// ignored; any other character that is not a digit of the base clears
// is_valid. The value wraps modulo 2^VALUE_WIDTH. The block takes one item in
// every cycle unless a last character is held: an item is captured in the
// input register, its character is folded into the accumulator as it leaves
// that register, through shifts and an add, and the last character of a token
// loads the result register with the folded value as it leaves. The result
// register decouples the two sides, so items keep flowing while a result
// waits; only a last character that finds the result register still full
// waits in the input register. Nothing needs to be written before use.
`default_nettype none
`include "assert_macros.svh"
module integer_literal_parser #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       token_valid,
  output logic                      token_ready,
  input  wire  ilp_pkg::symbol_t    symbol,
  input  wire                       end_of_token,
  output logic                      result_valid,
  input  wire                       result_ready,
  output logic                      is_valid,
  output logic signed [63:0]        number
);
  import ilp_pkg::*;

  // Input register.
  logic    tok_full;
  symbol_t tok_symbol;
  logic    tok_end;

  // Parse state.
  char_pos_t              char_position, char_position_next;
  radix_mode_t            radix_mode, radix_mode_next;
  logic                   pending_b_prefix, pending_b_prefix_next;
  logic [VALUE_WIDTH-1:0] accumulator, accumulator_next;
  logic                   still_valid, still_valid_next;

  // Character fold.
  logic                   take_en;
  radix_mode_t            take_mode;
  logic                   take_force_bad;
  logic [VALUE_WIDTH-1:0] scaled;
  digit_t                 digit;
  logic                   digit_ok;
  logic [VALUE_WIDTH-1:0] take_acc;
  logic                   take_valid;

  logic advance;
  logic load_result;
  logic token_valid_flag;

  // The held item moves on unless it ends a token and the result slot is busy.
  assign advance     = tok_full && (!tok_end || !result_valid || result_ready);
  assign load_result = advance && tok_end;
  assign token_ready = !tok_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_full <= 1'b0;
    end else if (token_ready) begin
      tok_full <= token_valid;
    end
    if (token_ready && token_valid) begin
      tok_symbol <= symbol;
      tok_end    <= end_of_token;
    end
  end

  // One character folded into the accumulator: value * base + digit, with
  // the multiply by ten built from two shifts.
  always_comb begin
    digit = digit_of(tok_symbol);
    unique case (take_mode)
      MODE_HEX: begin
        scaled   = accumulator << 4;
        digit_ok = (digit < 5'd16);
      end
      MODE_BIN: begin
        scaled   = accumulator << 1;
        digit_ok = (digit < 5'd2);
      end
      default: begin
        scaled   = (accumulator << 3) + (accumulator << 1);
        digit_ok = (digit < 5'd10);
      end
    endcase
    take_acc   = accumulator;
    take_valid = still_valid && !take_force_bad;
    if (tok_symbol != CHAR_UNDERSCORE) begin
      if (digit_ok) begin
        take_acc = scaled + VALUE_WIDTH'(digit);
      end else begin
        take_acc   = scaled;
        take_valid = 1'b0;
      end
    end
  end

  // Prefix handling and the choice of base for this character.
  always_comb begin
    char_position_next    = char_position;
    radix_mode_next       = radix_mode;
    pending_b_prefix_next = pending_b_prefix;
    accumulator_next      = accumulator;
    still_valid_next      = still_valid;
    take_en               = 1'b0;
    take_mode             = radix_mode;
    take_force_bad        = 1'b0;
    unique case (char_position)
      POS_FIRST: begin
        char_position_next = POS_SECOND;
        if (tok_symbol == CHAR_LOWER_B || tok_symbol == CHAR_UPPER_B) begin
          pending_b_prefix_next = 1'b1;
        end else begin
          radix_mode_next = (tok_symbol == CHAR_ZERO) ? MODE_ZERO : MODE_DEC;
          take_en         = 1'b1;
          take_mode       = MODE_DEC;
        end
      end
      POS_SECOND: begin
        char_position_next = POS_LATER;
        if (pending_b_prefix) begin
          pending_b_prefix_next = 1'b0;
          take_en               = 1'b1;
          if (tok_symbol == CHAR_ZERO || tok_symbol == CHAR_ONE) begin
            radix_mode_next = MODE_BIN;
            take_mode       = MODE_BIN;
          end else begin
            // The 'b' was no prefix: it counts as a bad decimal character,
            // which leaves the still-zero accumulator at zero.
            radix_mode_next = MODE_DEC;
            take_mode       = MODE_DEC;
            take_force_bad  = 1'b1;
          end
        end else if (radix_mode == MODE_ZERO && tok_symbol == CHAR_LOWER_X) begin
          radix_mode_next  = MODE_HEX;
          accumulator_next = '0;
          still_valid_next = 1'b1;
        end else begin
          if (radix_mode == MODE_ZERO) begin
            radix_mode_next = MODE_DEC;
          end
          take_en = 1'b1;
        end
      end
      POS_LATER: begin
        take_en = 1'b1;
      end
      default: begin
        char_position_next = POS_FIRST;
      end
    endcase
    if (take_en) begin
      accumulator_next = take_acc;
      still_valid_next = take_valid;
    end
  end

  // A token that is a lone 'b' ends with the 'b' read as a bad decimal digit.
  assign token_valid_flag = still_valid_next && !pending_b_prefix_next;

  always_ff @(posedge clk) begin
    if (rst || load_result) begin
      char_position    <= POS_FIRST;
      radix_mode       <= MODE_DEC;
      pending_b_prefix <= 1'b0;
      accumulator      <= '0;
      still_valid      <= 1'b1;
    end else if (advance) begin
      char_position    <= char_position_next;
      radix_mode       <= radix_mode_next;
      pending_b_prefix <= pending_b_prefix_next;
      accumulator      <= accumulator_next;
      still_valid      <= still_valid_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_result) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (load_result) begin
      is_valid <= token_valid_flag;
      number   <= NUMBER_WIDTH'(signed'(accumulator_next));
    end
  end

  // After a token ends, the next character starts from a clean state.
  `ILP_ASSERT(a_clean_after_token, clk, rst,
      load_result |=> (char_position == POS_FIRST && accumulator == '0 && still_valid))
  // An open 'b' prefix only exists right after the first character.
  `ILP_ASSERT(a_pending_b_position, clk, rst,
      pending_b_prefix |-> (char_position == POS_SECOND && accumulator == '0))
  // The leading-zero mode never outlives the second character.
  `ILP_ASSERT(a_zero_mode_position, clk, rst,
      (radix_mode == MODE_ZERO) |-> (char_position == POS_SECOND))
  // Hex and binary are only chosen once the prefix is complete.
  `ILP_ASSERT(a_radix_after_prefix, clk, rst,
      (radix_mode == MODE_HEX || radix_mode == MODE_BIN) |-> (char_position == POS_LATER))
  // A held item that cannot move on stays in the input register.
  `ILP_ASSERT(a_held_item_kept, clk, rst,
      (tok_full && !advance) |=> (tok_full && $stable(tok_symbol) && $stable(tok_end)))

endmodule
`default_nettype wire
